// ===== rtl/lsbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbsd_pkg: shared types and constants of the LSB stego stream decoder
// Phase and kind codes, configuration defaults and the section state record.
// ----------------------------------------------------------------------------
package lsbsd_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SKIP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_SKIP    = 2'd2;
    localparam int unsigned CFG_DATA_W  = 10;

    // Register values after reset.
    localparam logic [9:0] HEADER_SKIP_RST = 10'd54;
    localparam logic [3:0] MAGIC_COUNT_RST = 4'd2;
    localparam logic [7:0] GAP_SKIP_RST    = 8'd8;

    // Index of the last byte lane of the little-endian size word.
    localparam logic [1:0] SIZE_LAST_LANE = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXTCHAR = 3'd3,
        PH_SIZE    = 3'd4,
        PH_GAP     = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_MAGIC   = 3'd0,
        KIND_EXTLEN  = 3'd1,
        KIND_EXTCHAR = 3'd2,
        KIND_SIZE    = 3'd3,
        KIND_PAYLOAD = 3'd4
    } kind_t;

    typedef struct packed {
        logic [9:0] header_skip;
        logic [3:0] magic_count;
        logic [7:0] gap_skip;
    } cfg_t;

    // Position inside the hidden stream.
    typedef struct packed {
        phase_t      phase;
        logic [9:0]  skip_count;
        logic [31:0] field_count;
        logic [2:0]  bit_index;
        logic [7:0]  assembling;
    } sect_t;

endpackage

// ===== rtl/lsbsd_settle.sv =====
// ----------------------------------------------------------------------------
// lsbsd_settle: section advance logic
// Moves past each used-up header, magic, ext-char or gap section, with the
// register values of this cycle, before the next image byte is used.
// ----------------------------------------------------------------------------
module lsbsd_settle (
    input  lsbsd_pkg::sect_t cur,
    input  lsbsd_pkg::cfg_t  cfg,
    input  logic [7:0]       ext_length,
    input  logic [31:0]      payload_size,
    output lsbsd_pkg::sect_t eff,
    output logic             size_clear
);
    import lsbsd_pkg::*;

    always_comb begin
        eff        = cur;
        size_clear = 1'b0;

        if (eff.phase == PH_HEADER && eff.skip_count >= cfg.header_skip) begin
            eff = '{phase: PH_MAGIC, default: '0};
        end
        if (eff.phase == PH_MAGIC && eff.field_count >= {28'd0, cfg.magic_count}) begin
            eff = '{phase: PH_EXTLEN, default: '0};
        end
        if (eff.phase == PH_EXTCHAR && eff.field_count >= {24'd0, ext_length}) begin
            eff        = '{phase: PH_SIZE, default: '0};
            size_clear = 1'b1;
        end
        if (eff.phase == PH_GAP && eff.skip_count >= {2'd0, cfg.gap_skip}) begin
            // A size that is zero or negative as a signed word has no payload.
            if (payload_size == 32'd0 || payload_size[31]) begin
                eff = '{phase: PH_DONE, default: '0};
            end else begin
                eff = '{phase: PH_PAYLOAD, default: '0};
            end
        end
    end

endmodule

// ===== rtl/lsb_stego_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_stream_decoder_top: LSB steganography stream decoder
// Recovers hidden bytes from the least significant bits of an image file
// stream and tags each one with its place in the hidden record.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_image_byte[7:0]
//   m_        out        m_valid / m_ready   m_decoded_byte[7:0], m_kind[2:0], m_last
//   cfg_      in         cfg_wr_en           cfg_index[1:0], cfg_data[9:0]
//
// The section advance, the bit insert and the counter updates all sit
// between the state registers and the result register, so one item can be
// accepted in every cycle while s_ready is high.
// A result appears on m_ in the cycle after the eighth image byte of a hidden
// byte is accepted. The result register frees up in the same cycle in which
// its item is taken, so s_ready is low only while a result waits unread.
// Reset (aresetn low at a clock edge) returns to the header section and
// restores the register defaults of 54, 2 and 8.
// ----------------------------------------------------------------------------
module lsb_stego_stream_decoder_top (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_image_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_decoded_byte,
    output logic [2:0] m_kind,
    output logic       m_last,

    input  logic                              cfg_wr_en,
    input  logic [lsbsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsbsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsbsd_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Stream position and the fields decoded so far.
    sect_t       sect_reg, sect_next;
    logic [7:0]  ext_length_reg, ext_length_next;
    logic [31:0] payload_size_reg, payload_size_next;

    // Result register.
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    kind_t       m_kind_reg;
    logic        m_last_reg;

    // Section state after skipping the sections that are already complete.
    sect_t       eff;
    logic        size_clear;

    logic        accept;
    logic        res_valid;
    logic [7:0]  res_byte;
    kind_t       res_kind;
    logic        res_last;
    logic [7:0]  merged;
    logic [31:0] field_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_decoded_byte = m_byte_reg;
    assign m_kind         = m_kind_reg;
    assign m_last         = m_last_reg;

    // Configuration writes take effect on the next image byte. Unknown
    // indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_skip <= HEADER_SKIP_RST;
            cfg_reg.magic_count <= MAGIC_COUNT_RST;
            cfg_reg.gap_skip    <= GAP_SKIP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER_SKIP: cfg_reg.header_skip <= cfg_data;
                CFG_MAGIC_COUNT: cfg_reg.magic_count <= cfg_data[3:0];
                CFG_GAP_SKIP:    cfg_reg.gap_skip    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    lsbsd_settle u_settle (
        .cur          (sect_reg),
        .cfg          (cfg_reg),
        .ext_length   (ext_length_reg),
        .payload_size (payload_size_reg),
        .eff          (eff),
        .size_clear   (size_clear)
    );

    // Per-item work: count a skipped byte, drop a byte after the stream is done, or insert one hidden bit and,
    // on the eighth bit, hand the finished byte to the result register.
    always_comb begin
        sect_next         = eff;
        ext_length_next   = ext_length_reg;
        payload_size_next = size_clear ? 32'd0 : payload_size_reg;
        res_valid         = 1'b0;
        res_kind          = KIND_MAGIC;
        res_last          = 1'b0;
        merged            = eff.assembling | (8'(s_image_byte[0]) << eff.bit_index);
        res_byte          = merged;
        field_inc         = eff.field_count + 32'd1;

        case (eff.phase)
            PH_DONE: begin
            end
            PH_HEADER, PH_GAP: begin
                sect_next.skip_count = eff.skip_count + 10'd1;
            end
            default: begin
                if (eff.bit_index != 3'd7) begin
                    sect_next.bit_index  = eff.bit_index + 3'd1;
                    sect_next.assembling = merged;
                end else begin
                    sect_next.bit_index  = 3'd0;
                    sect_next.assembling = 8'd0;
                    res_valid            = 1'b1;
                    case (eff.phase)
                        PH_MAGIC: begin
                            res_kind              = KIND_MAGIC;
                            sect_next.field_count = field_inc;
                        end
                        PH_EXTLEN: begin
                            res_kind        = KIND_EXTLEN;
                            ext_length_next = merged;
                            sect_next       = '{phase: PH_EXTCHAR, default: '0};
                        end
                        PH_EXTCHAR: begin
                            res_kind              = KIND_EXTCHAR;
                            sect_next.field_count = field_inc;
                        end
                        PH_SIZE: begin
                            res_kind              = KIND_SIZE;
                            sect_next.field_count = field_inc;
                            case (eff.field_count[1:0])
                                2'd0:    payload_size_next[7:0]   = payload_size_next[7:0]   | merged;
                                2'd1:    payload_size_next[15:8]  = payload_size_next[15:8]  | merged;
                                2'd2:    payload_size_next[23:16] = payload_size_next[23:16] | merged;
                                default: payload_size_next[31:24] = payload_size_next[31:24] | merged;
                            endcase
                            if (eff.field_count[1:0] == SIZE_LAST_LANE) begin
                                sect_next = '{phase: PH_GAP, default: '0};
                            end
                        end
                        default: begin
                            // Payload: the byte that reaches the size is the
                            // final one, and the stream is finished after it.
                            res_kind              = KIND_PAYLOAD;
                            sect_next.field_count = field_inc;
                            res_last              = (field_inc == payload_size_reg);
                            if (res_last) begin
                                sect_next = '{phase: PH_DONE, default: '0};
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sect_reg         <= '{phase: PH_HEADER, default: '0};
            ext_length_reg   <= 8'd0;
            payload_size_reg <= 32'd0;
        end else if (accept) begin
            sect_reg         <= sect_next;
            ext_length_reg   <= ext_length_next;
            payload_size_reg <= payload_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_byte_reg <= res_byte;
            m_kind_reg <= res_kind;
            m_last_reg <= res_last;
        end
    end

    // The last flag belongs to payload bytes only.
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_kind_reg == KIND_PAYLOAD))
        else $error("last flag on a result that is not a payload byte");

    // Once the payload is complete the decoder stays finished until reset.
    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (sect_reg.phase == PH_DONE) |=> (sect_reg.phase == PH_DONE))
        else $error("decoder left the finished state without reset");

    // A partly built hidden byte exists only inside a bit-carrying section.
    a_bits_in_data_section: assert property (@(posedge aclk) disable iff (!aresetn)
        (sect_reg.bit_index != 3'd0) |->
            (sect_reg.phase != PH_HEADER && sect_reg.phase != PH_GAP &&
             sect_reg.phase != PH_DONE))
        else $error("hidden bits pending in a skip or finished section");

    // Items taken after the stream is finished produce no result.
    a_no_result_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && eff.phase == PH_DONE && !m_valid_reg) |=> !m_valid_reg)
        else $error("result produced after the payload was complete");

endmodule
